// ===== rtl/core/ascm_pkg.sv =====
// ----------------------------------------------------------------------------
// ascm_pkg
// Types, register codes and constants shared by the annular sector
// membership pipeline.
// ----------------------------------------------------------------------------
package ascm_pkg;

	// configuration register codes
	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_CENTRE   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_AXIS     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ZERO_DIR = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_R_INNER  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_R_OUTER  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_A_START  = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_A_END    = 3'd6;

	localparam int HalfTurn = 18000;
	localparam int FullTurn = 36000;

	localparam int SqrtSteps   = 32;
	localparam int CordicSteps = 25;
	localparam int DivSteps    = 17;
	localparam int CordW       = 56;
	localparam int AccW        = 29;

	// round(atan(2^-i) in degrees * 409600), unit 1/4096 of a hundredth of a degree
	localparam logic signed [AccW-1:0] AtanTab [CordicSteps] = '{
		29'sd18432000, 29'sd10881045, 29'sd5749245, 29'sd2918407, 29'sd1464867,
		29'sd733147, 29'sd366663, 29'sd183343, 29'sd91673, 29'sd45837,
		29'sd22918, 29'sd11459, 29'sd5730, 29'sd2865, 29'sd1432,
		29'sd716, 29'sd358, 29'sd179, 29'sd90, 29'sd45,
		29'sd22, 29'sd11, 29'sd6, 29'sd3, 29'sd1
	};

	typedef struct packed {
		logic [23:0]        cell_id;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} pt_t;

	typedef struct packed {
		logic [23:0] cell_id_out;
		logic        inside_res;
		logic [16:0] sigma;
	} res_t;

	// configuration as the datapath sees it
	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [15:0] zx;
		logic signed [15:0] zy;
		logic signed [15:0] zz;
		logic signed [18:0] bx;
		logic signed [18:0] by;
		logic signed [18:0] bz;
		logic signed [34:0] cpx;
		logic signed [34:0] cpy;
		logic signed [34:0] cpz;
		logic [30:0]        r_inner;
		logic [30:0]        r_outer;
		logic [30:0]        width;
		logic signed [17:0] ang_st;
		logic signed [17:0] ang_en;
	} cfg_t;

	// projected offset, reduced to squared length and plane coordinates
	typedef struct packed {
		logic [23:0]        cell_id;
		logic [63:0]        sq;
		logic signed [50:0] u;
		logic signed [53:0] v;
	} vec_t;

	typedef struct packed {
		logic [23:0]        cell_id;
		logic [31:0]        radius;
		logic signed [15:0] angle;
	} pol_t;

endpackage

// ===== rtl/core/annular_sector_membership_unit.sv =====
// ----------------------------------------------------------------------------
// annular_sector_membership_unit
// Annular sector membership test for one 3D point per beat.
// ----------------------------------------------------------------------------
// Takes one point beat per clock while the result side does not stall; the
// pipeline has 59 register stages (7 for projection, 34 for the square root
// and CORDIC, which run side by side with one bit or one rotation per stage,
// and 18 for the sector test and the divider that forms sigma one quotient
// bit per stage). A stall on the result side holds the whole pipeline;
// nothing is dropped or repeated. Configuration writes are always taken and
// their derived values are registered; write them only while no points are
// in flight.
module annular_sector_membership_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pt_valid,
	output logic                           pt_ready,
	input  ascm_pkg::pt_t                  pt,
	output logic                           res_valid,
	input  logic                           res_ready,
	output ascm_pkg::res_t                 res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ascm_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [63:0]                    cfg_data
);
	import ascm_pkg::*;

	cfg_t cfg;
	vec_t vec;
	pol_t pol;
	logic vec_vld;
	logic pol_vld;
	logic en;

	assign en       = !res_valid || res_ready;
	assign pt_ready = en;

	ascm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ascm_proj u_proj (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (pt_valid),
		.pt      (pt),
		.cfg     (cfg),
		.out_vld (vec_vld),
		.vec     (vec)
	);

	ascm_polar u_polar (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vec_vld),
		.vec     (vec),
		.out_vld (pol_vld),
		.pol     (pol)
	);

	ascm_sigma u_sigma (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (pol_vld),
		.pol     (pol),
		.cfg     (cfg),
		.out_vld (res_valid),
		.res     (res)
	);

`ifndef SYNTHESIS
	a_sigma_needs_inside: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.sigma == '0) || res.inside_res)
		else $error("sigma set for a point outside the sector");

	a_sigma_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.sigma <= 17'd65536)
		else $error("sigma above one");

	a_zero_width: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (cfg.width == '0) |-> res.sigma == '0)
		else $error("sigma set with zero radial width");
`endif

endmodule

// ===== rtl/core/ascm_cfg.sv =====
// ----------------------------------------------------------------------------
// ascm_cfg
// Configuration registers and the values derived from them (cross vector,
// projected centre, wrapped angles, radial width).
// ----------------------------------------------------------------------------
module ascm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ascm_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [63:0]                    cfg_data,
	output ascm_pkg::cfg_t                 cfg
);
	import ascm_pkg::*;

	logic [59:0] centre_q;
	logic [47:0] axis_q;
	logic [47:0] zero_q;
	logic [30:0] r_inner_q;
	logic [30:0] r_outer_q;
	logic [16:0] a_start_q;
	logic [16:0] a_end_q;

	logic signed [15:0] a [3];
	logic signed [15:0] z [3];
	logic signed [27:0] c [3];

	logic signed [31:0] zap_q [6];
	logic signed [18:0] b_q [3];
	logic signed [43:0] ca_q [3];
	logic signed [31:0] dc_q;
	logic signed [47:0] dca_q [3];
	logic signed [27:0] c2_q [3];
	logic signed [27:0] c3_q [3];
	logic signed [34:0] cp_q [3];
	logic signed [17:0] st_q;
	logic signed [17:0] en_q;
	logic [30:0]        width_q;

	logic signed [45:0] ca_sum;
	logic signed [33:0] bd [3];
	logic signed [48:0] dca_r [3];
	logic signed [17:0] st_w;
	logic signed [17:0] en_w;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q  <= '0;
			axis_q    <= '0;
			zero_q    <= '0;
			r_inner_q <= '0;
			r_outer_q <= '0;
			a_start_q <= '0;
			a_end_q   <= 17'(HalfTurn);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CENTRE:   centre_q  <= cfg_data[59:0];
				REG_AXIS:     axis_q    <= cfg_data[47:0];
				REG_ZERO_DIR: zero_q    <= cfg_data[47:0];
				REG_R_INNER:  r_inner_q <= cfg_data[30:0];
				REG_R_OUTER:  r_outer_q <= cfg_data[30:0];
				REG_A_START:  a_start_q <= cfg_data[16:0];
				REG_A_END:    a_end_q   <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i] = $signed(axis_q[16*i +: 16]);
			z[i] = $signed(zero_q[16*i +: 16]);
			c[i] = $signed({centre_q[20*i +: 20], 8'd0});
		end
	end

	// single wrap by a full turn
	function automatic logic signed [17:0] wrap_once(input logic [16:0] r);
		logic signed [17:0] w;
		w = $signed({r[16], r});
		if (w > HalfTurn)
			w = w - 18'(FullTurn);
		else if (w < -HalfTurn)
			w = w + 18'(FullTurn);
		return w;
	endfunction

	always_comb begin
		bd[0] = zap_q[0] - zap_q[1] + 34'sd8192;
		bd[1] = zap_q[2] - zap_q[3] + 34'sd8192;
		bd[2] = zap_q[4] - zap_q[5] + 34'sd8192;
		ca_sum = ca_q[0] + ca_q[1] + ca_q[2] + 46'sd8192;
		for (int i = 0; i < 3; i++)
			dca_r[i] = dca_q[i] + 49'sd8192;
		st_w = wrap_once(a_start_q);
		en_w = wrap_once(a_end_q);
	end

	// derived values are registered; the projected centre is formed through ca_q, dc_q, dca_q and cp_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				zap_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				b_q[i]   <= '0;
				ca_q[i]  <= '0;
				dca_q[i] <= '0;
				c2_q[i]  <= '0;
				c3_q[i]  <= '0;
				cp_q[i]  <= '0;
			end
			dc_q    <= '0;
			st_q    <= '0;
			en_q    <= 18'(HalfTurn);
			width_q <= '0;
		end else begin
			zap_q[0] <= z[1] * a[2];
			zap_q[1] <= z[2] * a[1];
			zap_q[2] <= z[2] * a[0];
			zap_q[3] <= z[0] * a[2];
			zap_q[4] <= z[0] * a[1];
			zap_q[5] <= z[1] * a[0];
			for (int i = 0; i < 3; i++) begin
				b_q[i]   <= 19'(bd[i] >>> 14);
				ca_q[i]  <= c[i] * a[i];
				dca_q[i] <= dc_q * a[i];
				c2_q[i]  <= c[i];
				c3_q[i]  <= c2_q[i];
				cp_q[i]  <= c3_q[i] - 35'(dca_r[i] >>> 14);
			end
			dc_q    <= 32'(ca_sum >>> 14);
			st_q    <= st_w;
			en_q    <= en_w;
			width_q <= (r_outer_q >= r_inner_q) ? r_outer_q - r_inner_q
				: r_inner_q - r_outer_q;
		end
	end

	always_comb begin
		cfg.ax      = a[0];
		cfg.ay      = a[1];
		cfg.az      = a[2];
		cfg.zx      = z[0];
		cfg.zy      = z[1];
		cfg.zz      = z[2];
		cfg.bx      = b_q[0];
		cfg.by      = b_q[1];
		cfg.bz      = b_q[2];
		cfg.cpx     = cp_q[0];
		cfg.cpy     = cp_q[1];
		cfg.cpz     = cp_q[2];
		cfg.r_inner = r_inner_q;
		cfg.r_outer = r_outer_q;
		cfg.width   = width_q;
		cfg.ang_st  = st_q;
		cfg.ang_en  = en_q;
	end

endmodule

// ===== rtl/core/ascm_proj.sv =====
// ----------------------------------------------------------------------------
// ascm_proj
// Seven-stage front end: removes the axis component, subtracts the projected
// centre, saturates, and forms the squared length and the plane coordinates.
// ----------------------------------------------------------------------------
module ascm_proj (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  ascm_pkg::pt_t   pt,
	input  ascm_pkg::cfg_t  cfg,
	output logic            out_vld,
	output ascm_pkg::vec_t  vec
);
	import ascm_pkg::*;

	logic [6:0] vld_q;

	logic signed [31:0] p [3];
	logic signed [15:0] a [3];
	logic signed [15:0] z [3];
	logic signed [18:0] b [3];
	logic signed [34:0] cp [3];

	logic [23:0]        id_s1, id_s2, id_s3, id_s4, id_s5, id_s6;
	logic signed [31:0] p_s1 [3];
	logic signed [31:0] p_s2 [3];
	logic signed [31:0] p_s3 [3];
	logic signed [47:0] pa_s1 [3];
	logic signed [35:0] d_s2;
	logic signed [51:0] da_s3 [3];
	logic signed [39:0] pp_s4 [3];
	logic signed [32:0] q_s5 [3];
	logic [63:0]        qq_s6 [3];
	logic signed [48:0] qz_s6 [3];
	logic signed [51:0] qb_s6 [3];
	vec_t               vec_s7;

	logic signed [50:0] dsum;
	logic signed [52:0] dar [3];
	logic signed [40:0] qd [3];
	logic signed [32:0] qsat [3];
	logic [32:0]        qmag [3];

	always_comb begin
		p[0]  = pt.point_x;
		p[1]  = pt.point_y;
		p[2]  = pt.point_z;
		a[0]  = cfg.ax;
		a[1]  = cfg.ay;
		a[2]  = cfg.az;
		z[0]  = cfg.zx;
		z[1]  = cfg.zy;
		z[2]  = cfg.zz;
		b[0]  = cfg.bx;
		b[1]  = cfg.by;
		b[2]  = cfg.bz;
		cp[0] = cfg.cpx;
		cp[1] = cfg.cpy;
		cp[2] = cfg.cpz;
		dsum = pa_s1[0] + pa_s1[1] + pa_s1[2] + 51'sd8192;
		for (int i = 0; i < 3; i++) begin
			dar[i] = da_s3[i] + 53'sd8192;
			qd[i]  = pp_s4[i] - cp[i];
			// clamp to +-2^31 (Q.16)
			if (qd[i] > 41'sd2147483648)
				qsat[i] = 33'sd2147483648;
			else if (qd[i] < -41'sd2147483648)
				qsat[i] = -33'sd2147483648;
			else
				qsat[i] = 33'(qd[i]);
			qmag[i] = q_s5[i][32] ? 33'(-q_s5[i]) : 33'(q_s5[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[5:0], in_vld};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			id_s1 <= pt.cell_id;
			id_s2 <= id_s1;
			id_s3 <= id_s2;
			id_s4 <= id_s3;
			id_s5 <= id_s4;
			id_s6 <= id_s5;
			for (int i = 0; i < 3; i++) begin
				p_s1[i]  <= p[i];
				pa_s1[i] <= p[i] * a[i];
				p_s2[i]  <= p_s1[i];
				p_s3[i]  <= p_s2[i];
				da_s3[i] <= d_s2 * a[i];
				pp_s4[i] <= p_s3[i] - 40'(dar[i] >>> 14);
				q_s5[i]  <= qsat[i];
				qq_s6[i] <= qmag[i][31:0] * qmag[i][31:0];
				qz_s6[i] <= q_s5[i] * z[i];
				qb_s6[i] <= q_s5[i] * b[i];
			end
			d_s2 <= 36'(dsum >>> 14);
			vec_s7.cell_id <= id_s6;
			vec_s7.sq      <= qq_s6[0] + qq_s6[1] + qq_s6[2];
			vec_s7.u       <= qz_s6[0] + qz_s6[1] + qz_s6[2];
			vec_s7.v       <= qb_s6[0] + qb_s6[1] + qb_s6[2];
		end
	end

	assign out_vld = vld_q[6];
	assign vec     = vec_s7;

endmodule

// ===== rtl/core/ascm_polar.sv =====
// ----------------------------------------------------------------------------
// ascm_polar
// Polar conversion: a bit-per-stage square root for the distance and a
// vectoring CORDIC for the angle, running side by side in one pipeline.
// ----------------------------------------------------------------------------
module ascm_polar (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  ascm_pkg::vec_t  vec,
	output logic            out_vld,
	output ascm_pkg::pol_t  pol
);
	import ascm_pkg::*;

	logic [SqrtSteps:0]         vld_q;
	logic [23:0]                id_q   [SqrtSteps+1];
	logic                       zero_q [SqrtSteps+1];
	logic signed [CordW-1:0]    cx_q   [SqrtSteps+1];
	logic signed [CordW-1:0]    cy_q   [SqrtSteps+1];
	logic signed [AccW-1:0]     acc_q  [SqrtSteps+1];
	logic [63:0]                n_q    [SqrtSteps+1];
	logic [33:0]                rem_q  [SqrtSteps+1];
	logic [31:0]                root_q [SqrtSteps+1];

	logic                       out_vld_q;
	pol_t                       pol_q;

	logic signed [CordW-1:0]    x0, y0;
	logic signed [AccW-1:0]     acc0;
	logic signed [AccW-1:0]     acc_rnd;
	logic signed [15:0]         ang;

	// quadrant fold: left half-plane is negated and starts at +-180 degrees
	always_comb begin
		if (vec.u < 0) begin
			x0 = -vec.u;
			y0 = -vec.v;
			acc0 = (vec.v >= 0) ? AccW'(HalfTurn * 4096) : -AccW'(HalfTurn * 4096);
		end else begin
			x0 = vec.u;
			y0 = vec.v;
			acc0 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0]  <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q[0]  <= in_vld;
			out_vld_q <= vld_q[SqrtSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			id_q[0]   <= vec.cell_id;
			zero_q[0] <= (vec.u == 0) && (vec.v == 0);
			cx_q[0]   <= x0;
			cy_q[0]   <= y0;
			acc_q[0]  <= acc0;
			n_q[0]    <= vec.sq;
			rem_q[0]  <= '0;
			root_q[0] <= '0;
		end
	end

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
		logic [35:0] r2;
		logic [33:0] trial;
		logic        take;

		assign r2    = {rem_q[k], n_q[k][63:62]};
		assign trial = {root_q[k], 2'b01};
		assign take  = r2 >= 36'(trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[k+1] <= 1'b0;
			else if (en)
				vld_q[k+1] <= vld_q[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				id_q[k+1]   <= id_q[k];
				zero_q[k+1] <= zero_q[k];
				n_q[k+1]    <= {n_q[k][61:0], 2'b00};
				rem_q[k+1]  <= take ? 34'(r2 - 36'(trial)) : r2[33:0];
				root_q[k+1] <= {root_q[k][30:0], take};
			end
		end

		if (k < CordicSteps) begin : g_rot
			logic signed [CordW-1:0] xs, ys;
			assign xs = cx_q[k] >>> k;
			assign ys = cy_q[k] >>> k;

			always_ff @(posedge clk) begin
				if (en) begin
					if (cy_q[k] > 0) begin
						cx_q[k+1]  <= cx_q[k] + ys;
						cy_q[k+1]  <= cy_q[k] - xs;
						acc_q[k+1] <= acc_q[k] + AtanTab[k];
					end else begin
						cx_q[k+1]  <= cx_q[k] - ys;
						cy_q[k+1]  <= cy_q[k] + xs;
						acc_q[k+1] <= acc_q[k] - AtanTab[k];
					end
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (en) begin
					cx_q[k+1]  <= cx_q[k];
					cy_q[k+1]  <= cy_q[k];
					acc_q[k+1] <= acc_q[k];
				end
			end
		end
	end

	// round to whole hundredths, clamp to a half turn
	always_comb begin
		acc_rnd = (acc_q[SqrtSteps] + $signed(AccW'(2048))) >>> 12;
		if (zero_q[SqrtSteps])
			ang = '0;
		else if (acc_rnd > HalfTurn)
			ang = 16'(HalfTurn);
		else if (acc_rnd < -HalfTurn)
			ang = -16'(HalfTurn);
		else
			ang = 16'(acc_rnd);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pol_q.cell_id <= id_q[SqrtSteps];
			pol_q.radius  <= root_q[SqrtSteps];
			pol_q.angle   <= ang;
		end
	end

	assign out_vld = out_vld_q;
	assign pol     = pol_q;

endmodule

// ===== rtl/core/ascm_sigma.sv =====
// ----------------------------------------------------------------------------
// ascm_sigma
// Sector and radius test, then a restoring divider, one quotient bit per
// stage, for the relative radial position. The last stage is the output beat.
// ----------------------------------------------------------------------------
module ascm_sigma (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  ascm_pkg::pol_t  pol,
	input  ascm_pkg::cfg_t  cfg,
	output logic            out_vld,
	output ascm_pkg::res_t  res
);
	import ascm_pkg::*;

	logic [DivSteps:0]  vld_q;
	logic [23:0]        id_q   [DivSteps+1];
	logic               in_q   [DivSteps+1];
	logic               keep_q [DivSteps+1];
	logic [31:0]        rem_q  [DivSteps+1];
	logic [16:0]        quo_q  [DivSteps+1];

	logic in_ang;
	logic hit;

	always_comb begin
		if (cfg.ang_st < cfg.ang_en)
			in_ang = (cfg.ang_st <= pol.angle) && (pol.angle <= cfg.ang_en);
		else
			in_ang = (cfg.ang_st <= pol.angle) || (pol.angle <= cfg.ang_en);
		hit = (pol.radius >= 32'(cfg.r_inner))
			&& (pol.radius <= 32'(cfg.r_outer)) && in_ang;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q[0] <= 1'b0;
		else if (en)
			vld_q[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			id_q[0]   <= pol.cell_id;
			in_q[0]   <= hit;
			keep_q[0] <= hit && (cfg.width != '0);
			rem_q[0]  <= pol.radius - 32'(cfg.r_inner);
			quo_q[0]  <= '0;
		end
	end

	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		logic [31:0] r;
		logic        take;

		// first step tests the numerator itself (quotient may reach one)
		if (j == 0) begin : g_first
			assign r = rem_q[j];
		end else begin : g_next
			assign r = {rem_q[j][30:0], 1'b0};
		end
		assign take = r >= 32'(cfg.width);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[j+1] <= 1'b0;
			else if (en)
				vld_q[j+1] <= vld_q[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				id_q[j+1]   <= id_q[j];
				in_q[j+1]   <= in_q[j];
				keep_q[j+1] <= keep_q[j];
				rem_q[j+1]  <= take ? r - 32'(cfg.width) : r;
				quo_q[j+1]  <= {quo_q[j][15:0], take};
			end
		end
	end

	assign out_vld         = vld_q[DivSteps];
	assign res.cell_id_out = id_q[DivSteps];
	assign res.inside_res  = in_q[DivSteps];
	assign res.sigma       = quo_q[DivSteps] & {17{keep_q[DivSteps]}};

endmodule

// ===== tb/ascm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascm_checker
// Watches the point, result and configuration channels of the annular sector
// unit, predicts each result from its own copy of the registers and compares
// the result beats in order.
// ----------------------------------------------------------------------------
module ascm_checker (
	input  logic           clk,
	input  logic           pt_valid,
	input  logic           pt_ready,
	input  ascm_pkg::pt_t  pt,
	input  logic           res_valid,
	input  logic           res_ready,
	input  ascm_pkg::res_t res,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [63:0]    cfg_data,
	output int             mismatches,
	output int             outstanding
);
	import ascm_pkg::*;

	logic [59:0] centre_r;
	logic [47:0] axis_r, zdir_r;
	logic [30:0] rin_r, rout_r;
	logic [16:0] ast_r, aen_r;

	res_t membership_q[$];

	initial begin
		centre_r = '0; axis_r = '0; zdir_r = '0;
		rin_r = '0; rout_r = '0; ast_r = '0; aen_r = 17'd18000;
		mismatches = 0;
	end

	assign outstanding = membership_q.size();

	function automatic longint rnd_sh(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint polar_angle(longint x, longint y);
		longint acc, xs, ys;
		acc = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			acc = (y >= 0) ? longint'(HalfTurn) * 4096 : -longint'(HalfTurn) * 4096;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CordicSteps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; acc += longint'(AtanTab[i]);
			end else begin
				x -= ys; y += xs; acc -= longint'(AtanTab[i]);
			end
		end
		acc = (acc + 2048) >>> 12;
		if (acc > HalfTurn) acc = HalfTurn;
		if (acc < -HalfTurn) acc = -HalfTurn;
		return acc;
	endfunction

	function automatic longint wrap_angle(logic [16:0] r);
		longint a;
		a = longint'($signed(r));
		if (a > HalfTurn) a -= FullTurn;
		if (a < -HalfTurn) a += FullTurn;
		return a;
	endfunction

	function automatic res_t predict_membership(pt_t p);
		longint a[3], z[3], b[3], pv[3], c[3], q[3];
		longint dp, dc, u, v, ang, st, en, rad, ri, ro, w, s;
		longint unsigned sq;
		logic in_ang, ins;
		res_t r;
		for (int i = 0; i < 3; i++) begin
			a[i] = longint'($signed(axis_r[16*i +: 16]));
			z[i] = longint'($signed(zdir_r[16*i +: 16]));
			c[i] = longint'($signed(centre_r[20*i +: 20])) * 256;
		end
		pv[0] = longint'(p.point_x);
		pv[1] = longint'(p.point_y);
		pv[2] = longint'(p.point_z);
		b[0] = rnd_sh(z[1] * a[2] - z[2] * a[1], 14);
		b[1] = rnd_sh(z[2] * a[0] - z[0] * a[2], 14);
		b[2] = rnd_sh(z[0] * a[1] - z[1] * a[0], 14);
		dp = rnd_sh(pv[0] * a[0] + pv[1] * a[1] + pv[2] * a[2], 14);
		dc = rnd_sh(c[0] * a[0] + c[1] * a[1] + c[2] * a[2], 14);
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			q[i] = (pv[i] - rnd_sh(dp * a[i], 14)) - (c[i] - rnd_sh(dc * a[i], 14));
			if (q[i] > 64'sd2147483648) q[i] = 64'sd2147483648;
			if (q[i] < -64'sd2147483648) q[i] = -64'sd2147483648;
			sq += longint'(q[i] * q[i]);
		end
		rad = longint'(int_sqrt(sq));
		u = q[0] * z[0] + q[1] * z[1] + q[2] * z[2];
		v = q[0] * b[0] + q[1] * b[1] + q[2] * b[2];
		ang = polar_angle(u, v);
		st = wrap_angle(ast_r);
		en = wrap_angle(aen_r);
		if (st < en) in_ang = (st <= ang) && (ang <= en);
		else in_ang = (st <= ang) || (ang <= en);
		ri = longint'(rin_r);
		ro = longint'(rout_r);
		ins = (rad >= ri) && (rad <= ro) && in_ang;
		w = ro - ri;
		if (w < 0) w = -w;
		s = 0;
		if (ins && w != 0) begin
			s = ((rad - ri) * 65536) / w;
			if (s > 65536) s = 65536;
			if (s < 0) s = 0;
		end
		r.cell_id_out = p.cell_id;
		r.inside_res = ins;
		r.sigma = s[16:0];
		return r;
	endfunction

	always @(posedge clk) begin
		res_t e;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTRE:   centre_r = cfg_data[59:0];
				REG_AXIS:     axis_r = cfg_data[47:0];
				REG_ZERO_DIR: zdir_r = cfg_data[47:0];
				REG_R_INNER:  rin_r = cfg_data[30:0];
				REG_R_OUTER:  rout_r = cfg_data[30:0];
				REG_A_START:  ast_r = cfg_data[16:0];
				REG_A_END:    aen_r = cfg_data[16:0];
				default: ;
			endcase
		end
		if (pt_valid && pt_ready) membership_q.push_back(predict_membership(pt));
		if (res_valid && res_ready) begin
			if (membership_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat: %p", res);
			end else begin
				e = membership_q.pop_front();
				if (e.cell_id_out !== res.cell_id_out || e.inside_res !== res.inside_res ||
				    e.sigma !== res.sigma) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp id=%0d in=%0d sig=%0d, got id=%0d in=%0d sig=%0d",
						         e.cell_id_out, e.inside_res, e.sigma,
						         res.cell_id_out, res.inside_res, res.sigma);
				end
			end
		end
	end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the annular sector unit: register settings phase by phase,
// directed and random points, bursty sender and stalling receiver; the
// checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb;
	import ascm_pkg::*;

	logic clk, arst_n;
	logic pt_valid, pt_ready, res_valid, res_ready, cfg_valid, cfg_ready;
	pt_t pt;
	res_t res;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;
	int mismatches, outstanding;
	int stall_cycles;
	bit hold_go;
	int idle_cycles;

	localparam int Unit = 16384;
	localparam int WatchdogLimit = 20000;

	annular_sector_membership_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.pt_valid(pt_valid), .pt_ready(pt_ready), .pt(pt),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ascm_checker u_checker (
		.clk(clk), .pt_valid(pt_valid), .pt_ready(pt_ready), .pt(pt),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: own stall pattern, plus a long hold-off on request
	always @(posedge clk) begin
		int mode, hold_cnt;
		if (hold_go) begin
			hold_cnt = 400;
			hold_go = 0;
		end
		mode = int'(($time / 2048) % 4);
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_ready <= 1'b0;
		end else begin
			case (mode)
				0: res_ready <= 1'b1;
				1: res_ready <= ($urandom_range(3, 0) != 0);
				2: res_ready <= ($urandom_range(9, 0) < 3);
				default: res_ready <= (($time / 8) % 5 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((pt_valid && pt_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchdogLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every point has come back, then let the pipe and registers settle
	task automatic drain;
		pt_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	int burst_left;

	task automatic send_point(pt_t p);
		if (burst_left == 0) begin
			pt_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
			burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
		end
		burst_left--;
		pt_valid <= 1'b1;
		pt <= p;
		@(posedge clk);
		while (!pt_ready) @(posedge clk);
	endtask

	function automatic logic [47:0] pick_vec(int kind);
		logic [15:0] c[3];
		for (int i = 0; i < 3; i++) c[i] = '0;
		case (kind)
			0: c[$urandom_range(2, 0)] = 16'(Unit);
			1: c[$urandom_range(2, 0)] = 16'(-Unit);
			2: for (int i = 0; i < 3; i++) c[i] = 16'(int'($urandom_range(2 * Unit, 0)) - Unit);
			default: for (int i = 0; i < 3; i++) c[i] = 16'($urandom);
		endcase
		return {c[2], c[1], c[0]};
	endfunction

	function automatic pt_t rand_point(int span_bits);
		pt_t p;
		p.cell_id = 24'($urandom);
		if (span_bits >= 32) begin
			p.point_x = $urandom; p.point_y = $urandom; p.point_z = $urandom;
		end else begin
			p.point_x = $signed($urandom) >>> (32 - span_bits);
			p.point_y = $signed($urandom) >>> (32 - span_bits);
			p.point_z = $signed($urandom) >>> (32 - span_bits);
		end
		return p;
	endfunction

	function automatic logic [63:0] angle_word(int a);
		logic [63:0] w;
		w = 64'($urandom);
		w[16:0] = a[16:0];
		return w;
	endfunction

	initial begin
		pt_t p;
		int r1, r2;
		arst_n = 1'b0;
		pt_valid = 1'b0; pt = '0; res_ready = 1'b0;
		cfg_valid = 1'b0; cfg_index = REG_CENTRE; cfg_data = '0;
		burst_left = 0; hold_go = 0; idle_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: axis z, zero direction x, ring 1..10 m, sector from -90 to 90 degrees
		write_reg(REG_CENTRE, 64'd0);
		write_reg(REG_AXIS, {16'sd0, 16'(Unit), 16'sd0, 16'sd0});
		write_reg(REG_ZERO_DIR, {48'd0, 16'(Unit)});
		write_reg(REG_R_INNER, 64'(1 << 16));
		write_reg(REG_R_OUTER, 64'(10 << 16));
		write_reg(REG_A_START, angle_word(-9000));
		write_reg(REG_A_END, angle_word(9000));
		for (int i = 0; i < 20; i++) begin
			p.cell_id = (i == 0) ? 24'hFFFFFF : 24'(i);
			case (i)
				0: begin p.point_x = 32'h7FFFFFFF; p.point_y = 32'h7FFFFFFF; p.point_z = 32'h7FFFFFFF; end
				1: begin p.point_x = 32'h80000000; p.point_y = 32'h80000000; p.point_z = 32'h80000000; end
				2: begin p.point_x = 0; p.point_y = 0; p.point_z = 0; end
				3: begin p.point_x = 1 << 16; p.point_y = 0; p.point_z = 5 << 16; end
				4: begin p.point_x = 10 << 16; p.point_y = 0; p.point_z = -3; end
				5: begin p.point_x = (10 << 16) + 1; p.point_y = 0; p.point_z = 0; end
				6: begin p.point_x = -(5 << 16); p.point_y = 0; p.point_z = 0; end
				7: begin p.point_x = -(5 << 16); p.point_y = -1; p.point_z = 0; end
				8: begin p.point_x = 0; p.point_y = 5 << 16; p.point_z = 0; end
				9: begin p.point_x = 0; p.point_y = -(5 << 16); p.point_z = 0; end
				10: begin p.point_x = 3 << 16; p.point_y = 3 << 16; p.point_z = 1; end
				11: begin p.point_x = 3 << 16; p.point_y = -(3 << 16); p.point_z = 0; end
				12: begin p.point_x = 32'h80000000; p.point_y = 32'h7FFFFFFF; p.point_z = 0; end
				default: p = rand_point(20);
			endcase
			if (i >= 13) p.cell_id = 24'(i);
			send_point(p);
		end
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			write_reg(REG_CENTRE, (ph % 3 == 0) ? {$urandom, $urandom} :
			          64'({$signed($urandom_range(2048, 0) - 1024)}) & 64'hFFFFF);
			write_reg(REG_AXIS, (ph == 5) ? 64'd0 : {16'($urandom), pick_vec(ph % 4)});
			write_reg(REG_ZERO_DIR, {16'($urandom), pick_vec((ph + 1) % 4)});
			r1 = $urandom_range(8 << 16, 0);
			r2 = r1 + $urandom_range(12 << 16, 0);
			case (ph)
				1: begin r1 = 0; r2 = 32'h7FFFFFFF; end
				2: r2 = r1;
				3: begin r2 = r1; r1 = r1 + (3 << 16); end
				7: begin r1 = 32'h7FFFFFFF; r2 = 32'h7FFFFFFF; end
				default: ;
			endcase
			write_reg(REG_R_INNER, {$urandom, 1'b0, r1[30:0]});
			write_reg(REG_R_OUTER, {$urandom, 1'b0, r2[30:0]});
			case (ph)
				0: begin write_reg(REG_A_START, angle_word(-54000)); write_reg(REG_A_END, angle_word(54000)); end
				4: begin write_reg(REG_A_START, angle_word(17000)); write_reg(REG_A_END, angle_word(-17000)); end
				6: begin write_reg(REG_A_START, angle_word(4500)); write_reg(REG_A_END, angle_word(4500)); end
				8: begin write_reg(REG_A_START, angle_word(-18000)); write_reg(REG_A_END, angle_word(18000)); end
				9: begin write_reg(REG_A_START, angle_word(-36001)); write_reg(REG_A_END, angle_word(36001)); end
				default: begin
					write_reg(REG_A_START, angle_word($urandom_range(108000, 0) - 54000));
					write_reg(REG_A_END, angle_word($urandom_range(108000, 0) - 54000));
				end
			endcase
			for (int i = 0; i < 112; i++) begin
				if (ph == 3 && i == 10) hold_go = 1;
				if (ph == 6 && i == 56) drain();
				p = rand_point(($urandom_range(9, 0) == 0) ? 32 : $urandom_range(21, 16));
				send_point(p);
			end
			drain();
		end

		if (outstanding != 0 || mismatches != 0) begin
			$display("Mismatches found");
		end else begin
			$display("No mismatches found");
		end
		$finish;
	end
endmodule
